### src/lwd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwd_pkg
// Shared types, codes and arithmetic helpers of the 2-D lifting wavelet block.
// ----------------------------------------------------------------------------
package lwd_pkg;

  localparam int DATA_W    = 32;
  localparam int DIM_W     = 9;
  localparam int LVL_W     = 3;
  localparam int CFG_IDX_W = 2;
  localparam int Q_SHIFT   = 30;
  localparam int WIDE_W    = 34;

  localparam logic signed [DATA_W-1:0] SQRT2_Q30     = 32'sd1518500250;
  localparam logic signed [DATA_W-1:0] INV_SQRT2_Q30 = 32'sd759250125;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_RUN   = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [1:0] STATUS_READ   = 2'd0;
  localparam logic [1:0] STATUS_DONE   = 2'd1;
  localparam logic [1:0] STATUS_REJECT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVELS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 2'd3;

  typedef struct packed {
    logic [1:0]               kind;
    logic [7:0]               row;
    logic [7:0]               col;
    logic signed [DATA_W-1:0] sample;
  } lwd_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [1:0]               status;
  } lwd_out_t;

  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_LOAD,
    SEQ_PRED,
    SEQ_UPD,
    SEQ_SCALE,
    SEQ_STORE,
    SEQ_DONE
  } seq_state_t;

  typedef struct packed {
    logic scale;
    logic quarter;
    logic add;
  } alu_op_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } frm_req_t;

  function automatic logic signed [DATA_W-1:0] sat_wide(input logic signed [WIDE_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if ((v[WIDE_W-1:DATA_W-1] == '0) || (v[WIDE_W-1:DATA_W-1] == '1)) begin
      r = v[DATA_W-1:0];
    end else if (v[WIDE_W-1]) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

### src/lifting_dwt_2d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifting_dwt_2d
// Multi-level 2-D 5/3 lifting wavelet, forward or inverse, in place over an
// addressed frame memory.
// ----------------------------------------------------------------------------
// Writes and reads are accepted back to back while busy is low; a read
// result appears on out_item with out_strobe in the cycle after acceptance and
// must be taken then, since the receiver cannot stall. A run command holds
// busy high while the sequencer walks the frame memory: per line of n samples
// it loads the samples, runs the two lifting steps over each sample pair,
// scales them and stores them back, with two passes (rows, columns) per level
// over a region halving each level. The line buffer has a single read port.
// A rejected run answers in the cycle after acceptance and leaves the memory
// untouched.
// ----------------------------------------------------------------------------
module lifting_dwt_2d
  import lwd_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_LEVELS = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  lwd_in_t              in_item,
  output logic                 out_strobe,
  output lwd_out_t             out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [DIM_W-1:0]     cfg_data
);

  localparam int FAW = $clog2(MAX_WIDTH * MAX_HEIGHT);

  logic             direction_r;
  logic [LVL_W-1:0] levels_r;
  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;

  logic             accept, in_range, size_good, run_go;
  logic [FAW-1:0]   host_addr;
  frm_req_t         seq_req;
  logic [FAW-1:0]   seq_addr;
  logic [DATA_W-1:0] seq_wdata, frm_rdata;
  logic             seq_active, seq_done;
  logic             frm_we, frm_re;
  logic [FAW-1:0]   frm_waddr, frm_raddr;
  logic [DATA_W-1:0] frm_wdata;

  logic             out_strobe_r;
  logic [1:0]       out_status_r;
  logic             out_rd_r;

  function automatic logic size_ok(input logic [DIM_W-1:0] s, input logic [LVL_W-1:0] lv,
                                   input int lim);
    return (32'(s) <= lim) && (((s >> lv) << lv) == s) && ((s >> lv) >= DIM_W'(2));
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= 1'b0;
      levels_r    <= LVL_W'(1);
      width_r     <= DIM_W'(256);
      height_r    <= DIM_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_DIRECTION: direction_r <= cfg_data[0];
        CFG_LEVELS:    levels_r    <= cfg_data[LVL_W-1:0];
        CFG_WIDTH:     width_r     <= cfg_data;
        CFG_HEIGHT:    height_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    accept    = start && !busy;
    in_range  = (32'(in_item.row) < MAX_HEIGHT) && (32'(in_item.col) < MAX_WIDTH);
    host_addr = FAW'(in_item.row) * FAW'(MAX_WIDTH) + FAW'(in_item.col);
    size_good = (levels_r != '0) && (32'(levels_r) <= MAX_LEVELS) &&
                size_ok(width_r, levels_r, MAX_WIDTH) &&
                size_ok(height_r, levels_r, MAX_HEIGHT);
    run_go    = accept && (in_item.kind == KIND_RUN) && size_good;
    busy      = seq_active;
    frm_we    = seq_req.wr || (accept && (in_item.kind == KIND_WRITE) && in_range);
    frm_re    = seq_req.rd || (accept && (in_item.kind == KIND_READ) && in_range);
    frm_waddr = seq_active ? seq_addr : host_addr;
    frm_raddr = seq_active ? seq_addr : host_addr;
    frm_wdata = seq_active ? seq_wdata : in_item.sample;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= seq_done ||
                      (accept && (in_item.kind == KIND_READ ||
                                  (in_item.kind == KIND_RUN && !size_good)));
    end
  end

  always_ff @(posedge clk) begin
    out_rd_r <= accept && (in_item.kind == KIND_READ) && in_range;
    if (seq_done) begin
      out_status_r <= STATUS_DONE;
    end else if (in_item.kind == KIND_RUN) begin
      out_status_r <= STATUS_REJECT;
    end else begin
      out_status_r <= STATUS_READ;
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_item.status = out_status_r;
  assign out_item.value  = out_rd_r ? $signed(frm_rdata) : '0;

  lwd_ram #(
    .DEPTH (MAX_WIDTH * MAX_HEIGHT),
    .WIDTH (DATA_W)
  ) u_frame (
    .clk     (clk),
    .wr_en   (frm_we),
    .wr_addr (frm_waddr),
    .wr_data (frm_wdata),
    .rd_en   (frm_re),
    .rd_addr (frm_raddr),
    .rd_data (frm_rdata)
  );

  lwd_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .run          (run_go),
    .direction    (direction_r),
    .levels       (levels_r),
    .frame_width  (width_r),
    .frame_height (height_r),
    .frm_rdata    (frm_rdata),
    .frm_req      (seq_req),
    .frm_addr     (seq_addr),
    .frm_wdata    (seq_wdata),
    .active       (seq_active),
    .done         (seq_done)
  );

  a_rise_on_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a run command");

  a_read_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.status == STATUS_READ) |-> !busy)
    else $error("read result during a transform");

  a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.status == STATUS_DONE) |-> ($past(busy) && !busy))
    else $error("done result without a finished transform");

  a_no_host_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && frm_we) |-> seq_req.wr)
    else $error("host write reached frame memory during a transform");

endmodule

### src/lwd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwd_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lwd_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/lwd_lift_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwd_lift_alu
// Lifting update (predict or update step) and Q30 scaling with saturation.
// ----------------------------------------------------------------------------
module lwd_lift_alu
  import lwd_pkg::*;
(
  input  alu_op_t                    op,
  input  logic signed [DATA_W-1:0]   tgt,
  input  logic signed [DATA_W:0]     pair,
  input  logic signed [2*DATA_W-1:0] prod,
  output logic signed [DATA_W-1:0]   result
);

  logic signed [DATA_W:0]   shifted;
  logic signed [WIDE_W-1:0] tgt_w;
  logic signed [WIDE_W-1:0] shf_w;
  logic signed [WIDE_W-1:0] sum_w;

  always_comb begin
    shifted = op.quarter ? (pair >>> 2) : (pair >>> 1);
    tgt_w   = WIDE_W'(tgt);
    shf_w   = WIDE_W'(shifted);
    sum_w   = op.add ? (tgt_w + shf_w) : (tgt_w - shf_w);
    result  = op.scale ? sat_wide(prod[Q_SHIFT +: WIDE_W]) : sat_wide(sum_w);
  end

endmodule

### src/lwd_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwd_seq
// Pass sequencer: loads each line into the line buffer, lifts it there by
// read-modify-write steps, and stores it back to the frame memory.
// ----------------------------------------------------------------------------
module lwd_seq
  import lwd_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    run,
  input  logic                                    direction,
  input  logic [LVL_W-1:0]                        levels,
  input  logic [DIM_W-1:0]                        frame_width,
  input  logic [DIM_W-1:0]                        frame_height,
  input  logic [DATA_W-1:0]                       frm_rdata,
  output frm_req_t                                frm_req,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] frm_addr,
  output logic [DATA_W-1:0]                       frm_wdata,
  output logic                                    active,
  output logic                                    done
);

  localparam int FAW        = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int LINE_DEPTH = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int LBW        = $clog2(LINE_DEPTH);

  seq_state_t state_r, state_nxt;
  logic [1:0]       sub_r;
  logic [DIM_W-1:0] elem_r;
  logic [DIM_W-1:0] line_r;
  logic [LVL_W-1:0] lv_r;
  logic             cols_r;
  logic             second_r;

  logic signed [DATA_W-1:0]   a_r;
  logic signed [DATA_W:0]     pair_r;
  logic signed [2*DATA_W-1:0] prod_r;

  logic [DIM_W-1:0] cur_w, cur_h, len, nlines, half, map_idx;
  logic [DIM_W-1:0] na, nb, tgt_idx;
  logic [1:0]       last_sub;
  logic             elem_last, step_end, phase_end, line_last, lv_last;

  logic             lb_we, lb_re;
  logic [LBW-1:0]   lb_waddr, lb_raddr;
  logic [DATA_W-1:0] lb_wdata, lb_rdata;
  logic signed [DATA_W-1:0] alu_res, k_sel;
  alu_op_t          alu_op;
  logic [DIM_W-1:0] f_row, f_col;

  always_comb begin
    cur_w     = frame_width >> lv_r;
    cur_h     = frame_height >> lv_r;
    len       = cols_r ? cur_h : cur_w;
    nlines    = cols_r ? cur_w : cur_h;
    half      = len >> 1;
    map_idx   = elem_r[0] ? (half + (elem_r >> 1)) : (elem_r >> 1);
    line_last = (line_r == nlines - 1'b1);
    lv_last   = direction ? (lv_r == '0) : (lv_r == levels - 1'b1);
    unique case (state_r)
      SEQ_PRED, SEQ_UPD: last_sub = 2'd3;
      SEQ_SCALE:         last_sub = 2'd2;
      default:           last_sub = 2'd1;
    endcase
    if (state_r == SEQ_PRED || state_r == SEQ_UPD) begin
      elem_last = (elem_r == half - 1'b1);
    end else begin
      elem_last = (elem_r == len - 1'b1);
    end
    step_end  = (sub_r == last_sub);
    phase_end = step_end && elem_last;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SEQ_IDLE:  if (run) state_nxt = SEQ_LOAD;
      SEQ_LOAD:  if (phase_end) state_nxt = direction ? SEQ_SCALE : SEQ_PRED;
      SEQ_PRED:  if (phase_end) state_nxt = direction ? SEQ_STORE : SEQ_UPD;
      SEQ_UPD:   if (phase_end) state_nxt = direction ? SEQ_PRED : SEQ_SCALE;
      SEQ_SCALE: if (phase_end) state_nxt = direction ? SEQ_UPD : SEQ_STORE;
      SEQ_STORE: begin
        if (phase_end) begin
          state_nxt = (line_last && second_r && lv_last) ? SEQ_DONE : SEQ_LOAD;
        end
      end
      SEQ_DONE:  state_nxt = SEQ_IDLE;
      default:   state_nxt = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= SEQ_IDLE;
      sub_r    <= '0;
      elem_r   <= '0;
      line_r   <= '0;
      lv_r     <= '0;
      cols_r   <= 1'b0;
      second_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == SEQ_IDLE) begin
        sub_r    <= '0;
        elem_r   <= '0;
        line_r   <= '0;
        second_r <= 1'b0;
        cols_r   <= direction;
        lv_r     <= direction ? (levels - 1'b1) : '0;
      end else if (state_r != SEQ_DONE) begin
        if (step_end) begin
          sub_r  <= '0;
          elem_r <= elem_last ? '0 : elem_r + 1'b1;
        end else begin
          sub_r <= sub_r + 1'b1;
        end
        if (state_r == SEQ_STORE && phase_end) begin
          if (line_last) begin
            line_r <= '0;
            if (second_r) begin
              second_r <= 1'b0;
              cols_r   <= direction;
              lv_r     <= direction ? (lv_r - 1'b1) : (lv_r + 1'b1);
            end else begin
              second_r <= 1'b1;
              cols_r   <= !cols_r;
            end
          end else begin
            line_r <= line_r + 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    if (state_r == SEQ_PRED) begin
      na      = elem_r;
      nb      = elem_last ? (half - 2'd2) : (elem_r + 1'b1);
      tgt_idx = half + elem_r;
    end else begin
      na      = half + elem_r;
      nb      = (elem_r == '0) ? (half + 1'b1) : (half + elem_r - 1'b1);
      tgt_idx = elem_r;
    end
    k_sel = ((elem_r < half) != direction) ? SQRT2_Q30 : INV_SQRT2_Q30;
    alu_op.scale   = (state_r == SEQ_SCALE);
    alu_op.quarter = (state_r == SEQ_UPD);
    alu_op.add     = (state_r == SEQ_UPD) != direction;
    f_row = cols_r ? elem_r : line_r;
    f_col = cols_r ? line_r : elem_r;
  end

  always_comb begin
    lb_we      = 1'b0;
    lb_re      = 1'b0;
    lb_waddr   = LBW'(map_idx);
    lb_raddr   = LBW'(map_idx);
    lb_wdata   = frm_rdata;
    frm_req.rd = 1'b0;
    frm_req.wr = 1'b0;
    frm_addr   = FAW'(f_row) * FAW'(MAX_WIDTH) + FAW'(f_col);
    frm_wdata  = lb_rdata;
    active     = (state_r != SEQ_IDLE);
    done       = (state_r == SEQ_DONE);
    unique case (state_r)
      SEQ_LOAD: begin
        frm_req.rd = (sub_r == 2'd0);
        lb_we      = (sub_r == 2'd1);
      end
      SEQ_STORE: begin
        lb_re      = (sub_r == 2'd0);
        frm_req.wr = (sub_r == 2'd1);
      end
      SEQ_PRED, SEQ_UPD: begin
        lb_re    = (sub_r != 2'd3);
        lb_raddr = (sub_r == 2'd0) ? LBW'(na) : (sub_r == 2'd1) ? LBW'(nb) : LBW'(tgt_idx);
        lb_we    = (sub_r == 2'd3);
        lb_waddr = LBW'(tgt_idx);
        lb_wdata = alu_res;
      end
      SEQ_SCALE: begin
        lb_re    = (sub_r == 2'd0);
        lb_raddr = LBW'(elem_r);
        lb_we    = (sub_r == 2'd2);
        lb_waddr = LBW'(elem_r);
        lb_wdata = alu_res;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if ((state_r == SEQ_PRED || state_r == SEQ_UPD) && sub_r == 2'd1) begin
      a_r <= lb_rdata;
    end
    if ((state_r == SEQ_PRED || state_r == SEQ_UPD) && sub_r == 2'd2) begin
      pair_r <= (DATA_W+1)'(a_r) + (DATA_W+1)'($signed(lb_rdata));
    end
    if (state_r == SEQ_SCALE && sub_r == 2'd1) begin
      prod_r <= (2*DATA_W)'($signed(lb_rdata)) * (2*DATA_W)'(k_sel);
    end
  end

  lwd_ram #(
    .DEPTH (LINE_DEPTH),
    .WIDTH (DATA_W)
  ) u_line_buf (
    .clk     (clk),
    .wr_en   (lb_we),
    .wr_addr (lb_waddr),
    .wr_data (lb_wdata),
    .rd_en   (lb_re),
    .rd_addr (lb_raddr),
    .rd_data (lb_rdata)
  );

  lwd_lift_alu u_alu (
    .op     (alu_op),
    .tgt    ($signed(lb_rdata)),
    .pair   (pair_r),
    .prod   (prod_r),
    .result (alu_res)
  );

endmodule
